// ===== hdl/u2a_pkg.sv =====
package u2a_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_LIMIT  = 21'h110000;
  localparam logic [CP_W-1:0] CP_SUPPL  = 21'h010000;
  localparam logic [15:0]     SURR_HIGH = 16'hD800;
  localparam logic [15:0]     SURR_LOW  = 16'hDC00;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  // One queue entry: an optional code point and an optional terminator.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            has_cp;
    logic            term;
    status_t         status;
  } entry_t;

  function automatic logic [7:0] unit_to_byte(logic [15:0] u);
    logic [7:0] r;
    if (u[15:8] == 8'h00) begin
      r = u[7:0];
    end else if (u >= 16'h0620 && u <= 16'h0636) begin
      r = u[7:0] - 8'h60;
    end else if (u >= 16'h0637 && u <= 16'h063A) begin
      r = u[7:0] - 8'h5F;
    end else if (u >= 16'h0641 && u <= 16'h0643) begin
      r = u[7:0] - 8'h64;
    end else if (u == 16'h0644) begin
      r = u[7:0] - 8'h63;
    end else if (u >= 16'h0645 && u <= 16'h0648) begin
      r = u[7:0] - 8'h62;
    end else if (u >= 16'h0649 && u <= 16'h064A) begin
      r = u[7:0] - 8'h5D;
    end else begin
      r = u[7:0] + 8'hA0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/u2a_if.sv =====
interface u2a_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface u2a_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic [1:0] status;

  modport source (output valid, out_byte, end_of_string, status, input ready);
  modport sink   (input valid, out_byte, end_of_string, status, output ready);
endinterface

// ===== hdl/u2a_front.sv =====
module u2a_front (
  input  logic              clk,
  input  logic              rst,
  u2a_byte_if.sink          utf8,
  input  logic              full,
  output logic              push,
  output u2a_pkg::entry_t   entry
);

  logic [u2a_pkg::CP_W-1:0] code_accum, code_accum_next;
  logic [1:0]               bytes_remaining, bytes_remaining_next;
  logic                     stopped, stopped_next;
  u2a_pkg::status_t         stop_status, stop_status_next;

  logic                     emit;
  logic [u2a_pkg::CP_W-1:0] emit_cp;
  logic [7:0]               b;
  logic                     last;
  logic                     accept;

  assign b          = utf8.in_byte;
  assign last       = utf8.last_byte;
  assign utf8.ready = !full;
  assign accept     = utf8.valid && !full;

  always_comb begin
    code_accum_next      = code_accum;
    bytes_remaining_next = bytes_remaining;
    stopped_next         = stopped;
    stop_status_next     = stop_status;
    emit                 = 1'b0;
    emit_cp              = code_accum;
    entry                = '0;

    if (!stopped) begin
      if (bytes_remaining != 2'd0) begin
        if (last && bytes_remaining > 2'd1) begin
          // cut short: pending code point dropped, terminator below
        end else if (b[7:6] == 2'b10) begin
          code_accum_next      = {code_accum[u2a_pkg::CP_W-7:0], b[5:0]};
          bytes_remaining_next = bytes_remaining - 2'd1;
          if (bytes_remaining == 2'd1) begin
            emit    = 1'b1;
            emit_cp = code_accum_next;
          end
        end else begin
          // bad continuation: emit partial, byte consumed
          bytes_remaining_next = 2'd0;
          emit                 = 1'b1;
          emit_cp              = code_accum;
        end
      end else if (!b[7]) begin
        emit    = 1'b1;
        emit_cp = u2a_pkg::CP_W'(b);
      end else if (b inside {[8'h80:8'hBF], [8'hF8:8'hFF]}) begin
        stopped_next     = 1'b1;
        stop_status_next = u2a_pkg::ST_BAD_LEAD;
      end else if (b < 8'hE0) begin
        code_accum_next      = u2a_pkg::CP_W'(b[4:0]);
        bytes_remaining_next = 2'd1;
      end else if (b < 8'hF0) begin
        code_accum_next      = u2a_pkg::CP_W'(b[3:0]);
        bytes_remaining_next = 2'd2;
      end else begin
        code_accum_next      = u2a_pkg::CP_W'(b[2:0]);
        bytes_remaining_next = 2'd3;
      end
    end

    if (emit) begin
      if (emit_cp < u2a_pkg::CP_LIMIT) begin
        entry.has_cp = 1'b1;
        entry.cp     = emit_cp;
      end else begin
        stopped_next     = 1'b1;
        stop_status_next = u2a_pkg::ST_TOO_LARGE;
      end
    end

    if (last) begin
      entry.term = 1'b1;
      if (stopped_next) begin
        entry.status = stop_status_next;
      end else if (bytes_remaining_next != 2'd0) begin
        entry.status = u2a_pkg::ST_TRUNCATED;
      end else begin
        entry.status = u2a_pkg::ST_OK;
      end
      code_accum_next      = '0;
      bytes_remaining_next = 2'd0;
      stopped_next         = 1'b0;
      stop_status_next     = u2a_pkg::ST_OK;
    end
  end

  assign push = accept && (entry.has_cp || entry.term);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum      <= '0;
      bytes_remaining <= 2'd0;
      stopped         <= 1'b0;
      stop_status     <= u2a_pkg::ST_OK;
    end else if (accept) begin
      code_accum      <= code_accum_next;
      bytes_remaining <= bytes_remaining_next;
      stopped         <= stopped_next;
      stop_status     <= stop_status_next;
    end
  end

endmodule

// ===== hdl/u2a_queue.sv =====
module u2a_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u2a_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output u2a_pkg::entry_t head,
  output logic            empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u2a_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/u2a_back.sv =====
module u2a_back (
  input  logic            clk,
  input  logic            rst,
  input  u2a_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  u2a_result_if.source    codepage
);

  typedef enum logic [1:0] {
    PH_UNIT,
    PH_LOW,
    PH_TERM
  } phase_t;

  phase_t     phase, cur_phase, phase_next;
  logic       mid;
  logic       load;
  logic       take;
  logic       last_piece;
  logic       suppl;
  logic [19:0] v;
  logic [15:0] unit;
  logic [7:0]  piece_byte;

  assign load = !codepage.valid || codepage.ready;
  assign take = load && !empty;

  assign suppl = (head.cp >= u2a_pkg::CP_SUPPL);
  assign v     = 20'(head.cp - u2a_pkg::CP_SUPPL);

  always_comb begin
    if (mid) begin
      cur_phase = phase;
    end else if (head.has_cp) begin
      cur_phase = PH_UNIT;
    end else begin
      cur_phase = PH_TERM;
    end

    unit       = head.cp[15:0];
    last_piece = 1'b1;
    phase_next = PH_TERM;
    case (cur_phase)
      PH_UNIT: begin
        if (suppl) begin
          unit       = u2a_pkg::SURR_HIGH | 16'(v[19:10]);
          last_piece = 1'b0;
          phase_next = PH_LOW;
        end else begin
          last_piece = !head.term;
        end
      end
      PH_LOW: begin
        unit       = u2a_pkg::SURR_LOW | 16'(v[9:0]);
        last_piece = !head.term;
      end
      PH_TERM: begin
        unit = 16'h0000;
      end
      default: begin
        unit = 16'h0000;
      end
    endcase
    piece_byte = u2a_pkg::unit_to_byte(unit);
  end

  assign pop = take && last_piece;

  always_ff @(posedge clk) begin
    if (rst) begin
      codepage.valid <= 1'b0;
      mid            <= 1'b0;
      phase          <= PH_UNIT;
    end else if (load) begin
      codepage.valid <= !empty;
      if (take) begin
        mid   <= !last_piece;
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (cur_phase == PH_TERM) begin
        codepage.out_byte      <= 8'h00;
        codepage.end_of_string <= 1'b1;
        codepage.status        <= head.status;
      end else begin
        codepage.out_byte      <= piece_byte;
        codepage.end_of_string <= 1'b0;
        codepage.status        <= u2a_pkg::ST_OK;
      end
    end
  end

endmodule

// ===== hdl/utf8_to_arabic_codepage.sv =====
// UTF-8 to Arabic single-byte code page converter.
// utf8: one UTF-8 byte per transfer, last_byte set on the final byte of a
//   string. codepage: one converted byte per transfer; the final transfer of
//   each string has end_of_string set, out_byte 0 and the string status.
// The front decodes one byte per cycle while the queue has room and writes
// at most one entry (code point and/or terminator) into a QUEUE_DEPTH-entry
// queue; bytes that give nothing write nothing. The back expands an entry
// into one to three output transfers, one per cycle while the receiver is
// ready, through an output register. The first result of a byte is written
// into the queue, then loaded into the output register driving codepage.
// Throughput: one input byte per cycle while the queue has room; output is
// one transfer per cycle when not stalled, so supplementary code points
// (two bytes) and terminators slow the input only once the queue fills.
// Reset clears decoder state, empties the queue and clears codepage.valid.
// When the receiver stalls, the output register holds, the queue fills and
// utf8.ready drops when the queue is full; nothing is lost.
module utf8_to_arabic_codepage #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input logic          clk,
  input logic          rst,
  u2a_byte_if.sink     utf8,
  u2a_result_if.source codepage
);

  logic            push, full, pop, empty;
  u2a_pkg::entry_t entry, head;

  u2a_front u_front (
    .clk   (clk),
    .rst   (rst),
    .utf8  (utf8),
    .full  (full),
    .push  (push),
    .entry (entry)
  );

  u2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  u2a_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .codepage (codepage)
  );

endmodule
